// ===== rtl/core/oac_pkg.sv =====
// oac_pkg: shared constants, types and tables of the obstacle avoidance cost block
// used by the top level and the port checker

package oac_pkg;

    localparam int OAC_MAX_OBSTACLES = 16;

    // field widths
    localparam int COORD_W  = 32;
    localparam int RADIUS_W = 31;
    localparam int HEAD_W   = 16;
    localparam int COST_W   = 48;
    localparam int SLOT_W   = 4;

    // one table entry: centre and radius
    localparam int ENTRY_W = 2 * COORD_W + RADIUS_W;

    // request kinds
    localparam logic MODE_WRITE = 1'b0;
    localparam logic MODE_EVAL  = 1'b1;

    // arithmetic constants
    localparam int          CORDIC_STEPS  = 30;
    localparam logic [33:0] CORDIC_GAIN   = 34'd652032874;
    localparam logic [31:0] LN2_Q32       = 32'd2977044472;
    localparam int          LOG_FRAC_BITS = 24;
    localparam logic [COST_W-1:0] COST_MAX = '1;

    typedef logic [COST_W-1:0] cost_t;

    // arctangent table of the rotation steps, Q2.30 quarter turns
    function automatic logic [30:0] oac_atan(input logic [4:0] idx);
        logic [30:0] val;
        unique case (idx)
            5'd0:    val = 31'd536870912;
            5'd1:    val = 31'd316933406;
            5'd2:    val = 31'd167458907;
            5'd3:    val = 31'd85004756;
            5'd4:    val = 31'd42667331;
            5'd5:    val = 31'd21354465;
            5'd6:    val = 31'd10679838;
            5'd7:    val = 31'd5340245;
            5'd8:    val = 31'd2670163;
            5'd9:    val = 31'd1335087;
            5'd10:   val = 31'd667544;
            5'd11:   val = 31'd333772;
            5'd12:   val = 31'd166886;
            5'd13:   val = 31'd83443;
            5'd14:   val = 31'd41722;
            5'd15:   val = 31'd20861;
            5'd16:   val = 31'd10430;
            5'd17:   val = 31'd5215;
            5'd18:   val = 31'd2608;
            5'd19:   val = 31'd1304;
            5'd20:   val = 31'd652;
            5'd21:   val = 31'd326;
            5'd22:   val = 31'd163;
            5'd23:   val = 31'd81;
            5'd24:   val = 31'd41;
            5'd25:   val = 31'd20;
            5'd26:   val = 31'd10;
            5'd27:   val = 31'd5;
            5'd28:   val = 31'd3;
            5'd29:   val = 31'd1;
            default: val = 31'd0;
        endcase
        return val;
    endfunction

endpackage

// ===== rtl/core/oac_ram.sv =====
// oac_ram: generic single write port, single read port ram with registered read
// no dependencies

module oac_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // write port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // registered read port
    always_ff @(posedge aclk) begin
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== rtl/core/obstacle_avoid_cost.sv =====
// obstacle_avoid_cost: potential field cost of a table of circular obstacles
// depends on oac_pkg and oac_ram

// A write request (mode 0) loads or clears one obstacle slot and gives no result; slots
// at or above MAX_OBSTACLES are ignored. An evaluate request (mode 1) projects own
// position along the heading, walks every slot and returns one cost and saturation
// flag. All multiplications run through one shared 34x34 multiplier under a small
// sequencer, one request at a time, and s_ready is low while an evaluation runs.
// An evaluation rotates the heading and projects the position, then reads each slot:
// an empty or distant slot is skipped, a slot within the square but outside the
// circle ends at the circle test, and a contributing slot takes a square root and
// two logarithms of up to 30 normalizing shifts plus 24 squarings each. A zero range
// or an overflow ends the walk early. The result is held in an output register, so
// writes are taken while a result waits; the next evaluation finishes only when the
// previous result has been taken.

module obstacle_avoid_cost #(
    parameter int MAX_OBSTACLES = oac_pkg::OAC_MAX_OBSTACLES
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  logic                       s_mode,
    input  logic [oac_pkg::SLOT_W-1:0] s_slot,
    input  logic                       s_slot_valid,
    input  logic signed [oac_pkg::COORD_W-1:0] s_obstacle_x,
    input  logic signed [oac_pkg::COORD_W-1:0] s_obstacle_y,
    input  logic [oac_pkg::RADIUS_W-1:0]       s_obstacle_radius,
    input  logic signed [oac_pkg::COORD_W-1:0] s_own_x,
    input  logic signed [oac_pkg::COORD_W-1:0] s_own_y,
    input  logic [oac_pkg::HEAD_W-1:0]         s_heading,
    input  logic [oac_pkg::RADIUS_W-1:0]       s_step_dist,
    output logic                       m_valid,
    input  logic                       m_ready,
    output logic [oac_pkg::COST_W-1:0] m_cost,
    output logic                       m_saturated
);
    import oac_pkg::*;

    localparam int AW = (MAX_OBSTACLES > 1) ? $clog2(MAX_OBSTACLES) : 1;
    localparam int SW = AW + SLOT_W;

    // sequencer states
    localparam logic [4:0] ST_IDLE = 5'd0;
    localparam logic [4:0] ST_CORD = 5'd1;
    localparam logic [4:0] ST_PC   = 5'd2;
    localparam logic [4:0] ST_PS   = 5'd3;
    localparam logic [4:0] ST_PY   = 5'd4;
    localparam logic [4:0] ST_RD   = 5'd5;
    localparam logic [4:0] ST_CHK  = 5'd6;
    localparam logic [4:0] ST_SQX  = 5'd7;
    localparam logic [4:0] ST_SQY  = 5'd8;
    localparam logic [4:0] ST_SQR  = 5'd9;
    localparam logic [4:0] ST_CMP  = 5'd10;
    localparam logic [4:0] ST_SQRT = 5'd11;
    localparam logic [4:0] ST_NRM  = 5'd12;
    localparam logic [4:0] ST_LSQ  = 5'd13;
    localparam logic [4:0] ST_LUP  = 5'd14;
    localparam logic [4:0] ST_LN   = 5'd15;
    localparam logic [4:0] ST_LNC  = 5'd16;
    localparam logic [4:0] ST_TM   = 5'd17;
    localparam logic [4:0] ST_TMC  = 5'd18;
    localparam logic [4:0] ST_NXT  = 5'd19;
    localparam logic [4:0] ST_DONE = 5'd20;

    logic [4:0] state_reg, state_next;

    // control
    logic [5:0]  cnt_reg, cnt_next;
    logic [AW-1:0] idx_reg, idx_next;
    logic        sat_reg, sat_next;
    logic        flip_reg, flip_next;
    logic        log_sel_reg, log_sel_next;
    logic [MAX_OBSTACLES-1:0] valid_reg;
    logic        m_valid_reg, m_valid_next;

    // datapath
    logic signed [33:0] x_reg, x_next, y_reg, y_next, z_reg, z_next;
    logic signed [33:0] px_reg, px_next, py_reg, py_next;
    logic signed [COORD_W-1:0] own_y_reg, own_y_next;
    logic [RADIUS_W-1:0] step_reg, step_next;
    logic [30:0] ax_reg, ax_next, ay_reg, ay_next, r_reg, r_next;
    logic [62:0] acc_reg, acc_next;
    logic [63:0] res_reg, res_next;
    logic [62:0] bit_reg, bit_next;
    logic [30:0] m_reg, m_next;
    logic [4:0]  e_reg, e_next;
    logic [LOG_FRAC_BITS-1:0] frac_reg, frac_next;
    logic [28:0] lr_reg, lr_next;
    logic [28:0] ln_reg, ln_next;
    cost_t       cost_reg, cost_next;
    cost_t       m_cost_reg, m_cost_next;
    logic        m_sat_reg, m_sat_next;

    // shared multiplier
    logic signed [33:0] mul_a, mul_b;
    logic signed [67:0] prod_reg;

    // table ram
    logic              accept;
    logic [SW-1:0]     slot_ext;
    logic              slot_ok;
    logic              tbl_wr;
    logic [ENTRY_W-1:0] tbl_rd;
    logic signed [COORD_W-1:0] tx, ty;
    logic [RADIUS_W-1:0] tr;

    assign accept   = s_valid && s_ready;
    assign slot_ext = SW'(s_slot);
    assign slot_ok  = slot_ext < SW'(MAX_OBSTACLES);
    assign tbl_wr   = accept && (s_mode == MODE_WRITE) && slot_ok;
    assign tx       = tbl_rd[ENTRY_W-1 -: COORD_W];
    assign ty       = tbl_rd[RADIUS_W +: COORD_W];
    assign tr       = tbl_rd[RADIUS_W-1:0];

    oac_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (MAX_OBSTACLES),
        .AW    (AW)
    ) u_table (
        .aclk    (aclk),
        .wr_en   (tbl_wr),
        .wr_addr (slot_ext[AW-1:0]),
        .wr_data ({s_obstacle_x, s_obstacle_y, s_obstacle_radius}),
        .rd_addr (idx_reg),
        .rd_data (tbl_rd)
    );

    // slot valid bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (tbl_wr) begin
            valid_reg[slot_ext[AW-1:0]] <= s_slot_valid;
        end
    end

    // combinational helpers
    logic signed [33:0] xs, ys, atan_s, cs_val;
    logic               hflip;
    logic [15:0]        a16;
    logic signed [34:0] ex, ey;
    logic [34:0]        axw, ayw;
    logic [63:0]        trial;
    logic [31:0]        sq_t;
    logic [28:0]        lg, dlog;
    logic [48:0]        sum;
    logic [35:0]        term;

    always_comb begin
        xs     = x_reg >>> cnt_reg[4:0];
        ys     = y_reg >>> cnt_reg[4:0];
        atan_s = $signed({3'b0, oac_atan(cnt_reg[4:0])});
        hflip  = s_heading[15] ^ s_heading[14];
        a16    = hflip ? {~s_heading[15], s_heading[14:0]} : s_heading;
        cs_val = flip_reg ? -((state_reg == ST_PC) ? x_reg : y_reg)
                          :  ((state_reg == ST_PC) ? x_reg : y_reg);
        ex     = {px_reg[33], px_reg} - {{3{tx[31]}}, tx};
        ey     = {py_reg[33], py_reg} - {{3{ty[31]}}, ty};
        axw    = ex[34] ? 35'(-ex) : 35'(ex);
        ayw    = ey[34] ? 35'(-ey) : 35'(ey);
        trial  = res_reg + {1'b0, bit_reg};
        sq_t   = prod_reg[61:30];
        lg     = {e_reg, frac_reg};
        dlog   = (lr_reg > lg) ? (lr_reg - lg) : 29'd0;
        term   = prod_reg[59:24];
        sum    = {1'b0, cost_reg} + {13'd0, term};
    end

    // multiplier operand select
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        unique case (state_reg)
            ST_PC, ST_PS: begin
                mul_a = $signed({3'b0, step_reg});
                mul_b = cs_val;
            end
            ST_SQX: begin
                mul_a = $signed({3'b0, ax_reg});
                mul_b = $signed({3'b0, ax_reg});
            end
            ST_SQY: begin
                mul_a = $signed({3'b0, ay_reg});
                mul_b = $signed({3'b0, ay_reg});
            end
            ST_SQR: begin
                mul_a = $signed({3'b0, r_reg});
                mul_b = $signed({3'b0, r_reg});
            end
            ST_LSQ: begin
                mul_a = $signed({3'b0, m_reg});
                mul_b = $signed({3'b0, m_reg});
            end
            ST_LN: begin
                mul_a = $signed({5'b0, dlog});
                mul_b = $signed({2'b0, LN2_Q32});
            end
            ST_TM: begin
                mul_a = $signed({3'b0, r_reg});
                mul_b = $signed({5'b0, ln_reg});
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        prod_reg <= mul_a * mul_b;
    end

    // sequencer
    always_comb begin
        state_next   = state_reg;
        cnt_next     = cnt_reg;
        idx_next     = idx_reg;
        sat_next     = sat_reg;
        flip_next    = flip_reg;
        log_sel_next = log_sel_reg;
        m_valid_next = m_valid_reg;
        x_next       = x_reg;
        y_next       = y_reg;
        z_next       = z_reg;
        px_next      = px_reg;
        py_next      = py_reg;
        own_y_next   = own_y_reg;
        step_next    = step_reg;
        ax_next      = ax_reg;
        ay_next      = ay_reg;
        r_next       = r_reg;
        acc_next     = acc_reg;
        res_next     = res_reg;
        bit_next     = bit_reg;
        m_next       = m_reg;
        e_next       = e_reg;
        frac_next    = frac_reg;
        lr_next      = lr_reg;
        ln_next      = ln_reg;
        cost_next    = cost_reg;
        m_cost_next  = m_cost_reg;
        m_sat_next   = m_sat_reg;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            // take a request; writes finish here
            ST_IDLE: begin
                if (accept && (s_mode == MODE_EVAL)) begin
                    flip_next  = hflip;
                    x_next     = $signed(CORDIC_GAIN);
                    y_next     = '0;
                    z_next     = $signed({{2{a16[15]}}, a16, 16'd0});
                    px_next    = {{2{s_own_x[31]}}, s_own_x};
                    own_y_next = s_own_y;
                    step_next  = s_step_dist;
                    cnt_next   = '0;
                    cost_next  = '0;
                    sat_next   = 1'b0;
                    state_next = ST_CORD;
                end
            end
            // one rotation step per cycle
            ST_CORD: begin
                if (!z_reg[33]) begin
                    x_next = x_reg - ys;
                    y_next = y_reg + xs;
                    z_next = z_reg - atan_s;
                end else begin
                    x_next = x_reg + ys;
                    y_next = y_reg - xs;
                    z_next = z_reg + atan_s;
                end
                cnt_next = cnt_reg + 6'd1;
                if (cnt_reg == 6'(CORDIC_STEPS - 1)) begin
                    state_next = ST_PC;
                end
            end
            ST_PC: begin
                state_next = ST_PS;
            end
            // projected point from the step products
            ST_PS: begin
                px_next    = px_reg + prod_reg[63:30];
                state_next = ST_PY;
            end
            ST_PY: begin
                py_next    = {{2{own_y_reg[31]}}, own_y_reg} + prod_reg[63:30];
                idx_next   = '0;
                state_next = ST_RD;
            end
            ST_RD: begin
                state_next = ST_CHK;
            end
            // valid bit and square bound test on the entry
            ST_CHK: begin
                r_next  = tr;
                ax_next = axw[30:0];
                ay_next = ayw[30:0];
                if (!valid_reg[idx_reg] || (axw >= {4'd0, tr}) || (ayw >= {4'd0, tr})) begin
                    state_next = ST_NXT;
                end else begin
                    state_next = ST_SQX;
                end
            end
            ST_SQX: begin
                state_next = ST_SQY;
            end
            ST_SQY: begin
                acc_next   = prod_reg[62:0];
                state_next = ST_SQR;
            end
            ST_SQR: begin
                acc_next   = acc_reg + prod_reg[62:0];
                state_next = ST_CMP;
            end
            // circle test, then start the square root
            ST_CMP: begin
                if (acc_reg >= prod_reg[62:0]) begin
                    state_next = ST_NXT;
                end else begin
                    res_next   = '0;
                    bit_next   = {1'b1, 62'd0};
                    cnt_next   = '0;
                    state_next = ST_SQRT;
                end
            end
            // restoring square root, one result bit per cycle
            ST_SQRT: begin
                if ({1'b0, acc_reg} >= trial) begin
                    acc_next = 63'({1'b0, acc_reg} - trial);
                    res_next = (res_reg >> 1) + {1'b0, bit_reg};
                end else begin
                    res_next = res_reg >> 1;
                end
                bit_next = bit_reg >> 2;
                cnt_next = cnt_reg + 6'd1;
                if (cnt_reg == 6'd31) begin
                    if (res_next == 64'd0) begin
                        sat_next   = 1'b1;
                        state_next = ST_DONE;
                    end else begin
                        m_next       = r_reg;
                        e_next       = 5'd30;
                        log_sel_next = 1'b0;
                        state_next   = ST_NRM;
                    end
                end
            end
            // normalize the mantissa one bit per cycle
            ST_NRM: begin
                if (m_reg[30]) begin
                    cnt_next   = '0;
                    state_next = ST_LSQ;
                end else begin
                    m_next = {m_reg[29:0], 1'b0};
                    e_next = e_reg - 5'd1;
                end
            end
            ST_LSQ: begin
                state_next = ST_LUP;
            end
            // one fraction bit per squaring
            ST_LUP: begin
                frac_next = {frac_reg[LOG_FRAC_BITS-2:0], sq_t[31]};
                m_next    = sq_t[31] ? sq_t[31:1] : sq_t[30:0];
                cnt_next  = cnt_reg + 6'd1;
                if (cnt_reg == 6'(LOG_FRAC_BITS - 1)) begin
                    if (!log_sel_reg) begin
                        lr_next      = {e_reg, frac_next};
                        m_next       = res_reg[30:0];
                        e_next       = 5'd30;
                        log_sel_next = 1'b1;
                        state_next   = ST_NRM;
                    end else begin
                        state_next = ST_LN;
                    end
                end else begin
                    state_next = ST_LSQ;
                end
            end
            ST_LN: begin
                state_next = ST_LNC;
            end
            ST_LNC: begin
                ln_next    = prod_reg[60:32];
                state_next = ST_TM;
            end
            ST_TM: begin
                state_next = ST_TMC;
            end
            // accumulate with overflow check
            ST_TMC: begin
                if (sum[48]) begin
                    sat_next   = 1'b1;
                    state_next = ST_DONE;
                end else begin
                    cost_next  = sum[47:0];
                    state_next = ST_NXT;
                end
            end
            ST_NXT: begin
                if (idx_reg == AW'(MAX_OBSTACLES - 1)) begin
                    state_next = ST_DONE;
                end else begin
                    idx_next   = idx_reg + AW'(1);
                    state_next = ST_RD;
                end
            end
            // hand the result to the output register once it is free
            ST_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    m_cost_next  = sat_reg ? COST_MAX : cost_reg;
                    m_sat_next   = sat_reg;
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // datapath registers
    always_ff @(posedge aclk) begin
        cnt_reg     <= cnt_next;
        idx_reg     <= idx_next;
        sat_reg     <= sat_next;
        flip_reg    <= flip_next;
        log_sel_reg <= log_sel_next;
        x_reg       <= x_next;
        y_reg       <= y_next;
        z_reg       <= z_next;
        px_reg      <= px_next;
        py_reg      <= py_next;
        own_y_reg   <= own_y_next;
        step_reg    <= step_next;
        ax_reg      <= ax_next;
        ay_reg      <= ay_next;
        r_reg       <= r_next;
        acc_reg     <= acc_next;
        res_reg     <= res_next;
        bit_reg     <= bit_next;
        m_reg       <= m_next;
        e_reg       <= e_next;
        frac_reg    <= frac_next;
        lr_reg      <= lr_next;
        ln_reg      <= ln_next;
        cost_reg    <= cost_next;
        m_cost_reg  <= m_cost_next;
        m_sat_reg   <= m_sat_next;
    end

    assign s_ready     = (state_reg == ST_IDLE);
    assign m_valid     = m_valid_reg;
    assign m_cost      = m_cost_reg;
    assign m_saturated = m_sat_reg;

endmodule

// ===== rtl/core/oac_check.sv =====
// oac_check: port level checks of obstacle_avoid_cost, bound to the top level
// depends on oac_pkg

module oac_check (
    input logic                       aclk,
    input logic                       aresetn,
    input logic                       s_valid,
    input logic                       s_ready,
    input logic                       s_mode,
    input logic                       m_valid,
    input logic                       m_ready,
    input logic [oac_pkg::COST_W-1:0] m_cost,
    input logic                       m_saturated
);
    import oac_pkg::*;

    // a held result keeps its value
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_cost) && $stable(m_saturated))
        else $error("result changed while stalled");

    // an evaluate request makes the block busy
    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && (s_mode == MODE_EVAL) |=> !s_ready)
        else $error("ready after evaluate request");

    // a write request finishes at once
    a_write: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && (s_mode == MODE_WRITE) |=> s_ready)
        else $error("busy after write request");

    // saturation forces the full scale cost
    a_sat: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_saturated |-> m_cost == COST_MAX)
        else $error("saturated cost not full scale");

endmodule

bind obstacle_avoid_cost oac_check u_oac_check (
    .aclk        (aclk),
    .aresetn     (aresetn),
    .s_valid     (s_valid),
    .s_ready     (s_ready),
    .s_mode      (s_mode),
    .m_valid     (m_valid),
    .m_ready     (m_ready),
    .m_cost      (m_cost),
    .m_saturated (m_saturated)
);
